>>> hdl/sidta_pkg.sv
// Shared constants and types for the signed integer to decimal ASCII converter.
package sidta_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = DIGITS * DIGIT_W;
    localparam int CNT_W   = $clog2(VALUE_W);
    localparam int LEFT_W  = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

    // Status of the binary to BCD unit
    typedef struct packed {
        logic busy;
        logic done;
    } dab_stat_t;

endpackage

>>> hdl/sidta_dabble.sv
// Bit-serial binary to BCD conversion (shift and add-3), one input bit per cycle.
module sidta_dabble (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [sidta_pkg::VALUE_W-1:0] mag,
    output sidta_pkg::dab_stat_t         stat,
    output logic [sidta_pkg::BCD_W-1:0]  bcd
);
    import sidta_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VALUE_W-1:0] bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int g = 0; g < DIGITS; g++) begin
            if (bcd_reg[g*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[g*DIGIT_W +: DIGIT_W] = bcd_reg[g*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                adj[g*DIGIT_W +: DIGIT_W] = bcd_reg[g*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VALUE_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            bin_reg <= mag;
            bcd_reg <= '0;
        end else if (busy_reg) begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule

>>> hdl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
// Takes one signed 32-bit value per request and emits its decimal text, most
// significant character first, one character per result request, with a
// leading '-' for negative values and m_last_char set on the final character.
// Zero gives "0"; the most negative value gives "-2147483648". One value is
// handled at a time. After acceptance a shift-add-3 unit builds ten BCD digits,
// which are then copied into the digit register. Leading zeros are dropped at
// one per cycle (up to nine) before output starts. Characters then leave at one
// per cycle while m_ready is high. The next value may be accepted while the
// final character is still waiting in the output register.
module signed_int_to_decimal_ascii (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [sidta_pkg::VALUE_W-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sidta_pkg::CHAR_W-1:0]  m_character,
    output logic                          m_last_char
);
    import sidta_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_TRIM = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [BCD_W-1:0]    digit_reg, digit_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_character_reg, m_character_next;
    logic                m_last_char_reg, m_last_char_next;

    logic                accept;
    logic                out_free;
    logic [VALUE_W-1:0]  mag;
    logic [DIGIT_W-1:0]  top_digit;
    dab_stat_t           dab_stat;
    logic [BCD_W-1:0]    dab_bcd;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    // unsigned negation, so the most negative value keeps its full magnitude
    assign mag       = s_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(s_value))
                                          : VALUE_W'(s_value);
    assign out_free  = !m_valid_reg || m_ready;
    assign top_digit = digit_reg[BCD_W-1 -: DIGIT_W];

    sidta_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .mag     (mag),
        .stat    (dab_stat),
        .bcd     (dab_bcd)
    );

    always_comb begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        digit_next       = digit_reg;
        left_next        = left_reg;
        m_valid_next     = m_valid_reg;
        m_character_next = m_character_reg;
        m_last_char_next = m_last_char_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next   = s_value[VALUE_W-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (dab_stat.done) begin
                    digit_next = dab_bcd;
                    left_next  = LEFT_W'(DIGITS);
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                // drop leading zeros, always keep the last digit
                if (top_digit == '0 && left_reg != LEFT_W'(1)) begin
                    digit_next = {digit_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    left_next  = left_reg - LEFT_W'(1);
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (neg_reg) begin
                        m_character_next = CHAR_MINUS;
                        m_last_char_next = 1'b0;
                        neg_next         = 1'b0;
                    end else begin
                        m_character_next = CHAR_ZERO + CHAR_W'(top_digit);
                        m_last_char_next = (left_reg == LEFT_W'(1));
                        digit_next = {digit_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        left_next  = left_reg - LEFT_W'(1);
                        if (left_reg == LEFT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg         <= neg_next;
        digit_reg       <= digit_next;
        left_reg        <= left_next;
        m_character_reg <= m_character_next;
        m_last_char_reg <= m_last_char_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last_char = m_last_char_reg;

`ifndef SYNTHESIS
    a_idle_unit_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !dab_stat.busy)
        else $error("conversion unit busy while idle");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CONV && dab_stat.busy))
        else $error("accepted request did not start conversion");

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT || state_reg == ST_TRIM) |->
            (left_reg != '0 && left_reg <= LEFT_W'(DIGITS)))
        else $error("digit count out of range");

    a_char_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_character == CHAR_MINUS ||
                     (m_character >= CHAR_ZERO && m_character <= CHAR_NINE)))
        else $error("bad character code");
`endif

endmodule
